// ===== hw/rtl/usli_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package usli_pkg;

  localparam int MAX_CHARS = 64;
  localparam int COUNT_W   = $clog2(MAX_CHARS + 1);
  localparam int ADDR_W    = $clog2(MAX_CHARS);
  localparam int CP_W      = 21;

  localparam int BYTE_W    = 8;
  localparam int OUTCOME_W = 3;
  localparam int REJ_W     = 2;
  localparam int SHOWN_W   = 7;
  localparam int MODE_W    = 2;
  localparam int MAXLEN_W  = 7;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 7;

  typedef logic [OUTCOME_W-1:0] outcome_t;
  typedef logic [REJ_W-1:0]     rejection_t;
  typedef logic [MODE_W-1:0]    mode_t;

  localparam outcome_t OUT_NONE    = 3'd0;
  localparam outcome_t OUT_CHANGED = 3'd1;
  localparam outcome_t OUT_REJECT  = 3'd2;
  localparam outcome_t OUT_SUBMIT  = 3'd3;
  localparam outcome_t OUT_CANCEL  = 3'd4;

  localparam rejection_t REJ_NONE    = 2'd0;
  localparam rejection_t REJ_UTF8    = 2'd1;
  localparam rejection_t REJ_CONTROL = 2'd2;
  localparam rejection_t REJ_MAXLEN  = 2'd3;

  localparam mode_t MODE_VISIBLE  = 2'd0;
  localparam mode_t MODE_OBSCURED = 2'd1;
  localparam mode_t MODE_SILENT   = 2'd2;
  localparam mode_t MODE_SPARE    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ECHO_MODE  = 1'd1;

  localparam logic [MAXLEN_W-1:0] MAXLEN_RESET = 7'd64;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_ETX = 8'h03;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_LF  = 8'h0a;
  localparam logic [7:0] CH_CR  = 8'h0d;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_ESC = 8'h1b;
  localparam logic [7:0] CH_DEL = 8'h7f;

  typedef logic [2:0] seq_len_t;

endpackage

`default_nettype wire

// ===== hw/rtl/usli_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface usli_in_if;
  logic                       valid;
  logic                       ready;
  logic [usli_pkg::BYTE_W-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/usli_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface usli_out_if;
  logic                          valid;
  logic                          ready;
  logic [usli_pkg::OUTCOME_W-1:0] outcome;
  logic [usli_pkg::REJ_W-1:0]     rejection;
  logic [usli_pkg::SHOWN_W-1:0]   shown_count;
  logic [usli_pkg::MODE_W-1:0]    shown_mode;

  modport source (output valid, output outcome, output rejection, output shown_count,
                  output shown_mode, input ready);
  modport sink   (input valid, input outcome, input rejection, input shown_count,
                  input shown_mode, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/utf8_secret_line_input.sv =====
// Secret line input: takes raw terminal bytes on in_ch, one request per byte, and
// returns exactly one feedback request on out_ch for each byte taken.
// UTF-8 sequences of 2 to 4 bytes are collected; the byte that completes one is
// decoded strictly and the code point is checked and pushed into the secret store.
// Edit bytes submit, delete, clear or cancel the line.
// Configuration: cfg_we with cfg_index 0 sets max_length, 1 sets echo_mode; write
// only while no feedback is outstanding.
// Feedback is registered and appears in the cycle after the byte is taken.
// Throughput: one byte per cycle unless out_ch stalls. The whole decode, check and
// count update are combinational; the character store is a 64 x 21 synchronous memory
// written at the current count in the cycle the byte is taken.
// Stall: the feedback register holds while out_ch.ready is low; in_ch.ready is high
// whenever that register is empty or being drained in the same cycle.
// Reset (rst, synchronous): empties the line, drops any pending sequence, sets
// max_length to 64 and echo_mode to obscured. The store needs no clearing.
`timescale 1ns / 1ps
`default_nettype none

module utf8_secret_line_input (
  input  wire                                clk,
  input  wire                                rst,
  usli_in_if.sink                            in_ch,
  usli_out_if.source                         out_ch,
  input  wire                                cfg_we,
  input  wire [usli_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [usli_pkg::CFG_W-1:0]          cfg_data
);

  logic [usli_pkg::CP_W-1:0] secret_store [usli_pkg::MAX_CHARS];

  logic [usli_pkg::COUNT_W-1:0]  char_count, char_count_next;
  logic [7:0]                    seq_b0, seq_b0_next;
  logic [7:0]                    seq_b1, seq_b1_next;
  logic [7:0]                    seq_b2, seq_b2_next;
  usli_pkg::seq_len_t            seq_have, seq_have_next;
  usli_pkg::seq_len_t            seq_need, seq_need_next;
  logic [usli_pkg::MAXLEN_W-1:0] max_length;
  usli_pkg::mode_t               echo_mode;

  logic                          out_valid;
  usli_pkg::outcome_t            res_outcome, res_outcome_next;
  usli_pkg::rejection_t          res_rej, res_rej_next;
  logic [usli_pkg::SHOWN_W-1:0]  res_count, res_count_next;
  usli_pkg::mode_t               res_mode, res_mode_next;

  logic                          accept;
  logic [7:0]                    b;
  logic                          push;
  logic [usli_pkg::CP_W-1:0]     push_cp;
  logic                          mem_we;
  logic [usli_pkg::ADDR_W-1:0]   mem_addr;
  logic [usli_pkg::CP_W-1:0]     mem_data;
  logic                          changed;
  logic [usli_pkg::CP_W-1:0]     cp;
  logic                          cp_ok;
  logic [usli_pkg::COUNT_W-1:0]  limit;
  usli_pkg::mode_t               mode_eff;

  function automatic logic unsafe_cp(input logic [usli_pkg::CP_W-1:0] c);
    return c < 21'h20 || (c >= 21'h7f && c <= 21'h9f) || c == 21'h061c ||
           c == 21'h200e || c == 21'h200f || (c >= 21'h202a && c <= 21'h202e) ||
           (c >= 21'h2066 && c <= 21'h2069);
  endfunction

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.in_byte;

  assign out_ch.valid       = out_valid;
  assign out_ch.outcome     = res_outcome;
  assign out_ch.rejection   = res_rej;
  assign out_ch.shown_count = res_count;
  assign out_ch.shown_mode  = res_mode;

  assign mode_eff = (echo_mode == usli_pkg::MODE_SPARE) ? usli_pkg::MODE_SILENT : echo_mode;
  assign limit    = (max_length < usli_pkg::COUNT_W'(usli_pkg::MAX_CHARS))
                    ? usli_pkg::COUNT_W'(max_length)
                    : usli_pkg::COUNT_W'(usli_pkg::MAX_CHARS);

  // decode of the sequence completed by the current byte
  always_comb begin
    cp    = '0;
    cp_ok = 1'b0;
    unique case (seq_need)
      3'd2: begin
        cp    = {10'd0, seq_b0[4:0], b[5:0]};
        cp_ok = cp >= 21'h80;
      end
      3'd3: begin
        cp    = {5'd0, seq_b0[3:0], seq_b1[5:0], b[5:0]};
        cp_ok = cp >= 21'h800 && !(cp >= 21'hd800 && cp <= 21'hdfff);
      end
      3'd4: begin
        cp    = {seq_b0[2:0], seq_b1[5:0], seq_b2[5:0], b[5:0]};
        cp_ok = cp >= 21'h10000 && cp <= 21'h10ffff;
      end
      default: begin
        cp    = '0;
        cp_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    char_count_next  = char_count;
    seq_b0_next      = seq_b0;
    seq_b1_next      = seq_b1;
    seq_b2_next      = seq_b2;
    seq_have_next    = seq_have;
    seq_need_next    = seq_need;
    res_outcome_next = usli_pkg::OUT_NONE;
    res_rej_next     = usli_pkg::REJ_NONE;
    res_count_next   = '0;
    res_mode_next    = '0;
    push             = 1'b0;
    push_cp          = '0;
    changed          = 1'b0;
    mem_we           = 1'b0;
    mem_addr         = char_count[usli_pkg::ADDR_W-1:0];
    mem_data         = '0;

    if (seq_have == 3'd0) begin
      priority if (b == usli_pkg::CH_NUL || b == usli_pkg::CH_CR || b == usli_pkg::CH_LF) begin
        res_outcome_next = usli_pkg::OUT_SUBMIT;
      end else if (b == usli_pkg::CH_BS || b == usli_pkg::CH_DEL) begin
        if (char_count != '0) char_count_next = char_count - 1'b1;
        changed = 1'b1;
      end else if (b == usli_pkg::CH_NAK) begin
        char_count_next = '0;
        changed         = 1'b1;
      end else if (b == usli_pkg::CH_ETX || b == usli_pkg::CH_EOT ||
                   b == usli_pkg::CH_ESC) begin
        char_count_next  = '0;
        seq_b0_next      = '0;
        seq_b1_next      = '0;
        seq_b2_next      = '0;
        seq_have_next    = '0;
        seq_need_next    = '0;
        res_outcome_next = usli_pkg::OUT_CANCEL;
      end else if (b >= 8'h20 && b <= 8'h7e) begin
        push    = 1'b1;
        push_cp = {13'd0, b};
      end else if (b >= 8'hc2 && b <= 8'hf4) begin
        seq_need_next = (b <= 8'hdf) ? 3'd2 : (b <= 8'hef) ? 3'd3 : 3'd4;
        seq_b0_next   = b;
        seq_have_next = 3'd1;
      end else if (b >= 8'h80) begin
        res_outcome_next = usli_pkg::OUT_REJECT;
        res_rej_next     = usli_pkg::REJ_UTF8;
      end else begin
        res_outcome_next = usli_pkg::OUT_REJECT;
        res_rej_next     = usli_pkg::REJ_CONTROL;
      end
    end else begin
      if (b < 8'h80 || b > 8'hbf || seq_have >= seq_need) begin
        seq_b0_next      = '0;
        seq_b1_next      = '0;
        seq_b2_next      = '0;
        seq_have_next    = '0;
        seq_need_next    = '0;
        res_outcome_next = usli_pkg::OUT_REJECT;
        res_rej_next     = usli_pkg::REJ_UTF8;
      end else if (seq_have + 3'd1 != seq_need) begin
        if (seq_have == 3'd1) seq_b1_next = b;
        else                  seq_b2_next = b;
        seq_have_next = seq_have + 3'd1;
      end else begin
        seq_b0_next   = '0;
        seq_b1_next   = '0;
        seq_b2_next   = '0;
        seq_have_next = '0;
        seq_need_next = '0;
        if (cp_ok) begin
          push    = 1'b1;
          push_cp = cp;
        end else begin
          res_outcome_next = usli_pkg::OUT_REJECT;
          res_rej_next     = usli_pkg::REJ_UTF8;
        end
      end
    end

    if (push) begin
      priority if (unsafe_cp(push_cp)) begin
        res_outcome_next = usli_pkg::OUT_REJECT;
        res_rej_next     = usli_pkg::REJ_CONTROL;
      end else if (char_count >= limit) begin
        res_outcome_next = usli_pkg::OUT_REJECT;
        res_rej_next     = usli_pkg::REJ_MAXLEN;
      end else begin
        mem_we          = accept;
        mem_data        = push_cp;
        char_count_next = char_count + 1'b1;
        changed         = 1'b1;
      end
    end

    if (changed) begin
      res_outcome_next = usli_pkg::OUT_CHANGED;
      res_mode_next    = mode_eff;
      res_count_next   = (mode_eff == usli_pkg::MODE_SILENT)
                         ? '0 : usli_pkg::SHOWN_W'(char_count_next);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      secret_store[mem_addr] <= mem_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count <= '0;
      seq_have   <= '0;
      seq_need   <= '0;
      seq_b0     <= '0;
      seq_b1     <= '0;
      seq_b2     <= '0;
      max_length <= usli_pkg::MAXLEN_RESET;
      echo_mode  <= usli_pkg::MODE_OBSCURED;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          usli_pkg::CFG_MAX_LENGTH: max_length <= cfg_data[usli_pkg::MAXLEN_W-1:0];
          usli_pkg::CFG_ECHO_MODE:  echo_mode  <= cfg_data[usli_pkg::MODE_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        char_count <= char_count_next;
        seq_have   <= seq_have_next;
        seq_need   <= seq_need_next;
        seq_b0     <= seq_b0_next;
        seq_b1     <= seq_b1_next;
        seq_b2     <= seq_b2_next;
        out_valid  <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_outcome <= res_outcome_next;
      res_rej     <= res_rej_next;
      res_count   <= res_count_next;
      res_mode    <= res_mode_next;
    end
  end

endmodule

`default_nettype wire

// ===== tb/utf8_secret_line_input_tb.sv =====
`timescale 1ns / 1ps

module utf8_secret_line_input_tb;

  localparam int QUIET_LIMIT = 400;

  typedef struct packed {
    usli_pkg::outcome_t                 outcome;
    usli_pkg::rejection_t               rejection;
    logic [usli_pkg::SHOWN_W-1:0]       count;
    usli_pkg::mode_t                    mode;
  } feedback_t;

  // Tracks the line editor state and queues the feedback each byte should produce.
  class secret_line_board;
    int unsigned                   chars;
    int unsigned                   have;
    int unsigned                   need;
    logic [7:0]                    seq [4];
    logic [usli_pkg::MAXLEN_W-1:0] max_len;
    usli_pkg::mode_t               echo;
    feedback_t                     feedback_due [$];
    int unsigned                   errors;
    int unsigned                   checked;
    int unsigned                   bytes_in;
    int unsigned                   tally [5];

    function new();
      chars = 0;
      drop_seq();
      max_len = usli_pkg::MAXLEN_RESET;
      echo = usli_pkg::MODE_OBSCURED;
      errors = 0;
      checked = 0;
      bytes_in = 0;
      foreach (tally[i]) tally[i] = 0;
    endfunction

    function void set_reg(logic [usli_pkg::CFG_IDX_W-1:0] idx,
                          logic [usli_pkg::CFG_W-1:0] val);
      if (idx == usli_pkg::CFG_MAX_LENGTH) max_len = val[usli_pkg::MAXLEN_W-1:0];
      else if (idx == usli_pkg::CFG_ECHO_MODE) echo = val[usli_pkg::MODE_W-1:0];
    endfunction

    function void drop_seq();
      have = 0;
      need = 0;
      foreach (seq[i]) seq[i] = 8'h00;
    endfunction

    function feedback_t plain(usli_pkg::outcome_t o);
      return {o, usli_pkg::REJ_NONE, 7'd0, usli_pkg::MODE_VISIBLE};
    endfunction

    function feedback_t reject(usli_pkg::rejection_t r);
      return {usli_pkg::OUT_REJECT, r, 7'd0, usli_pkg::MODE_VISIBLE};
    endfunction

    function feedback_t changed();
      usli_pkg::mode_t m;
      m = (echo == usli_pkg::MODE_SPARE) ? usli_pkg::MODE_SILENT : echo;
      return {usli_pkg::OUT_CHANGED, usli_pkg::REJ_NONE,
              (m == usli_pkg::MODE_SILENT) ? 7'd0 : usli_pkg::SHOWN_W'(chars), m};
    endfunction

    function bit unsafe_cp(int unsigned c);
      return c < 'h20 || (c >= 'h7f && c <= 'h9f) || c == 'h61c || c == 'h200e ||
             c == 'h200f || (c >= 'h202a && c <= 'h202e) || (c >= 'h2066 && c <= 'h2069);
    endfunction

    function feedback_t push_cp(int unsigned c);
      int unsigned limit;
      limit = (max_len < usli_pkg::MAX_CHARS) ? max_len : usli_pkg::MAX_CHARS;
      if (unsafe_cp(c)) return reject(usli_pkg::REJ_CONTROL);
      if (chars >= limit) return reject(usli_pkg::REJ_MAXLEN);
      chars++;
      return changed();
    endfunction

    // strict decode: no overlong forms, no surrogates, nothing past U+10FFFF
    function bit decode(output int unsigned c);
      int unsigned lowest;
      int unsigned i;
      case (need)
        2: begin c = seq[0][4:0]; lowest = 'h80; end
        3: begin c = seq[0][3:0]; lowest = 'h800; end
        4: begin c = seq[0][2:0]; lowest = 'h10000; end
        default: begin c = 0; return 1'b0; end
      endcase
      for (i = 1; i < need; i++) c = (c << 6) | seq[i][5:0];
      return !(c < lowest || (c >= 'hd800 && c <= 'hdfff) || c > 'h10ffff);
    endfunction

    function feedback_t predict_feedback(logic [7:0] b);
      int unsigned c;
      if (have == 0) begin
        if (b == usli_pkg::CH_NUL || b == usli_pkg::CH_CR || b == usli_pkg::CH_LF)
          return plain(usli_pkg::OUT_SUBMIT);
        if (b == usli_pkg::CH_BS || b == usli_pkg::CH_DEL) begin
          if (chars > 0) chars--;
          return changed();
        end
        if (b == usli_pkg::CH_NAK) begin
          chars = 0;
          return changed();
        end
        if (b == usli_pkg::CH_ETX || b == usli_pkg::CH_EOT || b == usli_pkg::CH_ESC) begin
          chars = 0;
          drop_seq();
          return plain(usli_pkg::OUT_CANCEL);
        end
        if (b >= 8'h20 && b <= 8'h7e) return push_cp(b);
        if (b >= 8'hc2 && b <= 8'hdf) need = 2;
        else if (b >= 8'he0 && b <= 8'hef) need = 3;
        else if (b >= 8'hf0 && b <= 8'hf4) need = 4;
        else if (b >= 8'h80) return reject(usli_pkg::REJ_UTF8);
        else return reject(usli_pkg::REJ_CONTROL);
        seq[0] = b;
        have = 1;
        return plain(usli_pkg::OUT_NONE);
      end
      if (b < 8'h80 || b > 8'hbf || have >= need) begin
        drop_seq();
        return reject(usli_pkg::REJ_UTF8);
      end
      seq[have] = b;
      have++;
      if (have != need) return plain(usli_pkg::OUT_NONE);
      if (!decode(c)) begin
        drop_seq();
        return reject(usli_pkg::REJ_UTF8);
      end
      drop_seq();
      return push_cp(c);
    endfunction

    function void take_byte(logic [7:0] b);
      bytes_in++;
      feedback_due.push_back(predict_feedback(b));
    endfunction

    function void report(string field, int want, int got);
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endfunction

    function void check_feedback(feedback_t got);
      feedback_t want;
      if (feedback_due.size() == 0) begin
        report("unexpected feedback, outcome", -1, got.outcome);
        return;
      end
      want = feedback_due.pop_front();
      checked++;
      tally[want.outcome]++;
      if (got.outcome !== want.outcome) report("outcome", want.outcome, got.outcome);
      if (got.rejection !== want.rejection) report("rejection", want.rejection, got.rejection);
      if (got.count !== want.count) report("shown_count", want.count, got.count);
      if (got.mode !== want.mode) report("shown_mode", want.mode, got.mode);
    endfunction

    function int pending();
      return feedback_due.size();
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic [usli_pkg::CFG_IDX_W-1:0] cfg_index = usli_pkg::CFG_MAX_LENGTH;
  logic [usli_pkg::CFG_W-1:0]     cfg_data = '0;
  bit                             steady = 1'b0;
  int                             quiet = 0;
  int                             settings = 1;
  logic [7:0]                     burst [$];
  secret_line_board               board;

  usli_in_if  in_ch ();
  usli_out_if out_ch ();

  utf8_secret_line_input dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      board.check_feedback({out_ch.outcome, out_ch.rejection, out_ch.shown_count,
                            out_ch.shown_mode});
    if (!rst && in_ch.valid && in_ch.ready) board.take_byte(in_ch.in_byte);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no request moved for %0d cycles", $time, QUIET_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  // feedback side: random stall before each request, none while steady is set
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      gap = steady ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_regs(logic [usli_pkg::MAXLEN_W-1:0] len, usli_pkg::mode_t mode);
    cfg_we <= 1'b1;
    cfg_index <= usli_pkg::CFG_MAX_LENGTH;
    cfg_data <= usli_pkg::CFG_W'(len);
    @(posedge clk);
    cfg_index <= usli_pkg::CFG_ECHO_MODE;
    cfg_data <= usli_pkg::CFG_W'(mode);
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_reg(usli_pkg::CFG_MAX_LENGTH, usli_pkg::CFG_W'(len));
    board.set_reg(usli_pkg::CFG_ECHO_MODE, usli_pkg::CFG_W'(mode));
    settings++;
  endtask

  function automatic int utf8_len(int unsigned c);
    if (c < 'h80) return 1;
    if (c < 'h800) return 2;
    if (c < 'h10000) return 3;
    return 4;
  endfunction

  // n-byte form of c; may be overlong or out of range on purpose
  function automatic void encode(int unsigned c, int n);
    case (n)
      1: burst.push_back(c[7:0]);
      2: begin
        burst.push_back({3'b110, c[10:6]});
        burst.push_back({2'b10, c[5:0]});
      end
      3: begin
        burst.push_back({4'b1110, c[15:12]});
        burst.push_back({2'b10, c[11:6]});
        burst.push_back({2'b10, c[5:0]});
      end
      default: begin
        burst.push_back({5'b11110, c[20:18]});
        burst.push_back({2'b10, c[17:12]});
        burst.push_back({2'b10, c[11:6]});
        burst.push_back({2'b10, c[5:0]});
      end
    endcase
  endfunction

  // bidi marks, C1 controls and their neighbors
  function automatic int unsigned edge_cp();
    case ($urandom_range(0, 13))
      0: return 'h61c;
      1: return 'h61b;
      2: return 'h200e;
      3: return 'h200f;
      4: return 'h200d;
      5: return 'h202a;
      6: return 'h202e;
      7: return 'h202f;
      8: return 'h2066;
      9: return 'h2069;
      10: return 'h206a;
      11: return 'h85;
      12: return 'h9f;
      default: return 'ha0;
    endcase
  endfunction

  function automatic void add_token();
    int          pick;
    int          n;
    int          k;
    int unsigned c;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      burst.push_back(8'($urandom_range('h20, 'h7e)));
    end else if (pick < 62) begin
      encode($urandom_range('h80, 'h7ff), 2);
    end else if (pick < 70) begin
      c = ($urandom_range(0, 5) == 0) ? $urandom_range('hd800, 'hdfff)
                                      : $urandom_range('h800, 'hffff);
      encode(c, 3);
    end else if (pick < 72) begin
      c = edge_cp();
      encode(c, utf8_len(c));
    end else if (pick < 76) begin
      encode($urandom_range('h10000, 'h10ffff), 4);
    end else if (pick < 78) begin
      encode($urandom_range('h110000, 'h13ffff), 4);
    end else if (pick < 81) begin
      n = $urandom_range(2, 4);
      c = $urandom_range(0, (n == 2) ? 'h7f : (n == 3) ? 'h7ff : 'hffff);
      encode(c, n);
    end else if (pick < 85) begin
      // truncated sequence followed by any byte
      n = $urandom_range(2, 4);
      case (n)
        2: burst.push_back(8'($urandom_range('hc2, 'hdf)));
        3: burst.push_back(8'($urandom_range('he0, 'hef)));
        default: burst.push_back(8'($urandom_range('hf0, 'hf4)));
      endcase
      k = $urandom_range(0, n - 2);
      repeat (k) burst.push_back(8'($urandom_range('h80, 'hbf)));
      burst.push_back(8'($urandom_range(0, 255)));
    end else if (pick < 89) begin
      burst.push_back($urandom_range(0, 1) ? usli_pkg::CH_BS : usli_pkg::CH_DEL);
    end else if (pick < 90) begin
      burst.push_back(usli_pkg::CH_NAK);
    end else if (pick < 91) begin
      case ($urandom_range(0, 2))
        0: burst.push_back(usli_pkg::CH_ETX);
        1: burst.push_back(usli_pkg::CH_EOT);
        default: burst.push_back(usli_pkg::CH_ESC);
      endcase
    end else if (pick < 94) begin
      case ($urandom_range(0, 2))
        0: burst.push_back(usli_pkg::CH_NUL);
        1: burst.push_back(usli_pkg::CH_CR);
        default: burst.push_back(usli_pkg::CH_LF);
      endcase
    end else begin
      burst.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  task automatic run_random(int count);
    int sent;
    sent = 0;
    while (sent < count) begin
      if (burst.size() == 0) add_token();
      send_byte(burst.pop_front());
      sent++;
    end
    burst.delete();
  endtask

  initial begin
    logic [7:0]                    opening [$];
    logic [usli_pkg::MAXLEN_W-1:0] len_set;
    usli_pkg::mode_t               mode_set;
    int                            count;
    int                            p;
    in_ch.valid = 1'b0;
    in_ch.in_byte = 8'h00;
    board = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    opening = '{8'h20, 8'h7e, 8'h01, usli_pkg::CH_BS, usli_pkg::CH_DEL, usli_pkg::CH_NAK,
                usli_pkg::CH_DEL, 8'h80, 8'hff,
                8'hc2, 8'h80,                    // C1 control via two bytes
                8'he0, 8'h80, 8'h80,             // overlong
                8'hed, 8'ha0, 8'h80,             // surrogate
                8'hf4, 8'h90, 8'h80, 8'h80,      // past U+10FFFF
                8'hc3, 8'h41,                    // ASCII breaks a sequence
                usli_pkg::CH_ETX, usli_pkg::CH_CR};
    foreach (opening[i]) send_byte(opening[i]);
    run_random(120);
    settle();

    for (p = 1; p < 6; p++) begin
      steady = 1'b0;
      case (p)
        1: begin len_set = 7'd0;   mode_set = usli_pkg::MODE_VISIBLE;  count = 50;  end
        2: begin
          len_set = 7'd3;
          mode_set = usli_pkg::MODE_SILENT;
          count = 80;
          steady = 1'b1;
        end
        3: begin len_set = 7'd127; mode_set = usli_pkg::MODE_SPARE;    count = 150; end
        4: begin len_set = 7'd64;  mode_set = usli_pkg::MODE_VISIBLE;  count = 120; end
        default: begin
          len_set = 7'($urandom_range(1, 70));
          mode_set = usli_pkg::mode_t'($urandom_range(0, 3));
          count = 80;
        end
      endcase
      write_regs(len_set, mode_set);
      run_random(count);
      settle();
    end

    repeat (4) @(posedge clk);
    $display("Sent %0d bytes under %0d register settings, %0d feedback requests checked.",
             board.bytes_in, settings, board.checked);
    $display("Outcomes: %0d pending, %0d changed, %0d rejected, %0d submit, %0d cancelled.",
             board.tally[usli_pkg::OUT_NONE], board.tally[usli_pkg::OUT_CHANGED],
             board.tally[usli_pkg::OUT_REJECT], board.tally[usli_pkg::OUT_SUBMIT],
             board.tally[usli_pkg::OUT_CANCEL]);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
